>>> design/hmbd_pkg.sv
// Shared types, codes and helpers for the HTTP message body deframer.
// No dependencies; hmbd_core, the top level and the checker use it by scoped names.
package hmbd_pkg;

	// Request operation codes
	typedef enum logic [2:0] {
		OP_DATA       = 3'd0,
		OP_START_HDR  = 3'd1,
		OP_START_LINE = 3'd2,
		OP_START_PAY  = 3'd3,
		OP_START_CHNK = 3'd4,
		OP_END_INPUT  = 3'd5
	} opcode_t;

	// Framing modes
	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_HEADER  = 3'd1,
		MODE_LINE    = 3'd2,
		MODE_PAYLOAD = 3'd3,
		MODE_CSIZE   = 3'd4,
		MODE_CDATA   = 3'd5,
		MODE_CTAIL   = 3'd6,
		MODE_TRAILER = 3'd7
	} mode_t;

	// Byte classification
	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_TEXT    = 2'd1,
		KIND_PAYLOAD = 2'd2,
		KIND_FRAMING = 2'd3
	} kind_t;

	// Result status
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_SIZE   = 2'd1,
		ST_NEED_CLOSE = 2'd2,
		ST_NO_MODE    = 2'd3
	} status_t;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam logic [1:0] NL_TARGET_HDR  = 2'd2;
	localparam logic [1:0] NL_TARGET_LINE = 2'd1;

	// Control state apart from the length counter
	typedef struct packed {
		mode_t      mode;
		logic [1:0] nl_count;
		logic [1:0] nl_target;
		logic       input_ended;
		logic       digit_seen;
		logic       tail_space;
	} ctl_state_t;

	// One result
	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      byte_kind;
		logic       section_last;
		logic       payload_consumed;
		status_t    status;
	} rsp_t;

	// Hex digit decode: {valid, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

>>> design/hmbd_if.sv
// Request and result channel interfaces of the message body deframer.
// Depends on nothing but the fixed field widths.
interface hmbd_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [7:0]  data_byte;
	logic [31:0] payload_length;

	modport source (output valid, output opcode, output data_byte, output payload_length,
		input ready);
	modport sink (input valid, input opcode, input data_byte, input payload_length,
		output ready);
endinterface

interface hmbd_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] byte_kind;
	logic       section_last;
	logic       payload_consumed;
	logic [1:0] status;

	modport source (output valid, output out_byte, output byte_kind, output section_last,
		output payload_consumed, output status, input ready);
	modport sink (input valid, input out_byte, input byte_kind, input section_last,
		input payload_consumed, input status, output ready);
endinterface

>>> design/hmbd_core.sv
// Next-state and result logic for one request of the deframer.
// Depends on hmbd_pkg; purely combinational, registered by the top level.
module hmbd_core #(
	parameter int LENGTH_BITS = 32
) (
	input  logic [2:0]             opcode,
	input  logic [7:0]             data_byte,
	input  logic [LENGTH_BITS-1:0] len,
	input  hmbd_pkg::ctl_state_t   st,
	input  logic [LENGTH_BITS-1:0] bytes_left,
	output hmbd_pkg::ctl_state_t   st_nxt,
	output logic [LENGTH_BITS-1:0] bytes_left_nxt,
	output hmbd_pkg::rsp_t         res
);

	logic [4:0]             hex;
	logic [1:0]             nl_inc;
	logic [1:0]             nl_cnt;
	logic                   nl_hit;
	logic [LENGTH_BITS-1:0] bl_dec;
	logic                   no_room;

	assign hex     = hmbd_pkg::hex_decode(data_byte);
	assign nl_inc  = st.nl_count + 2'd1;
	assign bl_dec  = bytes_left - LENGTH_BITS'(1);
	assign no_room = (bytes_left[LENGTH_BITS-1 -: 4] != 4'd0);

	// Newline counting: CR leaves the count, LF steps it, anything else clears it
	always_comb begin
		if (data_byte == hmbd_pkg::CH_CR) begin
			nl_cnt = st.nl_count;
			nl_hit = 1'b0;
		end else if (data_byte == hmbd_pkg::CH_LF) begin
			nl_cnt = nl_inc;
			nl_hit = (nl_inc == st.nl_target);
		end else begin
			nl_cnt = 2'd0;
			nl_hit = (st.nl_target == 2'd0);
		end
	end

	// Mode update and result fields
	always_comb begin
		st_nxt             = st;
		bytes_left_nxt     = bytes_left;
		res.out_byte       = 8'd0;
		res.byte_kind      = hmbd_pkg::KIND_NONE;
		res.section_last   = 1'b0;
		res.status         = hmbd_pkg::ST_OK;

		case (hmbd_pkg::opcode_t'(opcode))
			hmbd_pkg::OP_DATA: begin
				res.out_byte = data_byte;
				if (st.input_ended || st.mode == hmbd_pkg::MODE_IDLE) begin
					res.status = hmbd_pkg::ST_NO_MODE;
				end else begin
					case (st.mode)
						hmbd_pkg::MODE_HEADER, hmbd_pkg::MODE_LINE,
						hmbd_pkg::MODE_TRAILER: begin
							res.byte_kind = (st.mode == hmbd_pkg::MODE_TRAILER) ?
								hmbd_pkg::KIND_FRAMING : hmbd_pkg::KIND_TEXT;
							st_nxt.nl_count = nl_cnt;
							if (nl_hit) begin
								res.section_last = 1'b1;
								st_nxt.mode      = hmbd_pkg::MODE_IDLE;
								bytes_left_nxt   = '0;
							end
						end
						hmbd_pkg::MODE_PAYLOAD: begin
							res.byte_kind  = hmbd_pkg::KIND_PAYLOAD;
							bytes_left_nxt = bl_dec;
							if (bl_dec == '0) begin
								res.section_last = 1'b1;
								st_nxt.mode      = hmbd_pkg::MODE_IDLE;
							end
						end
						hmbd_pkg::MODE_CDATA: begin
							res.byte_kind  = hmbd_pkg::KIND_PAYLOAD;
							bytes_left_nxt = bl_dec;
							if (bl_dec == '0) begin
								st_nxt.mode = hmbd_pkg::MODE_CTAIL;
							end
						end
						hmbd_pkg::MODE_CTAIL: begin
							res.byte_kind = hmbd_pkg::KIND_FRAMING;
							if (data_byte == hmbd_pkg::CH_LF) begin
								st_nxt.mode       = hmbd_pkg::MODE_CSIZE;
								bytes_left_nxt    = '0;
								st_nxt.digit_seen = 1'b0;
								st_nxt.tail_space = 1'b0;
							end
						end
						hmbd_pkg::MODE_CSIZE: begin
							res.byte_kind = hmbd_pkg::KIND_FRAMING;
							if (data_byte == hmbd_pkg::CH_CR) begin
								// CR is skipped inside a size line
							end else if (data_byte == hmbd_pkg::CH_LF) begin
								if (!st.digit_seen) begin
									res.status = hmbd_pkg::ST_BAD_SIZE;
								end else if (bytes_left == '0) begin
									st_nxt.mode      = hmbd_pkg::MODE_TRAILER;
									st_nxt.nl_count  = 2'd1;
									st_nxt.nl_target = hmbd_pkg::NL_TARGET_HDR;
								end else begin
									st_nxt.mode = hmbd_pkg::MODE_CDATA;
								end
							end else if (data_byte == hmbd_pkg::CH_SPACE ||
								data_byte == hmbd_pkg::CH_TAB) begin
								if (st.digit_seen) begin
									st_nxt.tail_space = 1'b1;
								end
							end else if (hex[4] && !st.tail_space && !no_room) begin
								bytes_left_nxt    = {bytes_left[LENGTH_BITS-5:0], hex[3:0]};
								st_nxt.digit_seen = 1'b1;
							end else begin
								res.status = hmbd_pkg::ST_BAD_SIZE;
							end
							if (res.status == hmbd_pkg::ST_BAD_SIZE) begin
								st_nxt.mode    = hmbd_pkg::MODE_IDLE;
								bytes_left_nxt = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			hmbd_pkg::OP_START_HDR: begin
				if (!st.input_ended) begin
					if (st.mode == hmbd_pkg::MODE_PAYLOAD || st.mode == hmbd_pkg::MODE_CSIZE ||
						st.mode == hmbd_pkg::MODE_CDATA || st.mode == hmbd_pkg::MODE_CTAIL ||
						st.mode == hmbd_pkg::MODE_TRAILER) begin
						res.status = hmbd_pkg::ST_NEED_CLOSE;
					end else begin
						st_nxt.mode      = hmbd_pkg::MODE_HEADER;
						bytes_left_nxt   = '0;
						st_nxt.nl_count  = 2'd0;
						st_nxt.nl_target = hmbd_pkg::NL_TARGET_HDR;
					end
				end
			end
			hmbd_pkg::OP_START_LINE: begin
				if (st.input_ended) begin
					res.status = hmbd_pkg::ST_NEED_CLOSE;
				end else begin
					st_nxt.mode      = hmbd_pkg::MODE_LINE;
					bytes_left_nxt   = '0;
					st_nxt.nl_count  = 2'd0;
					st_nxt.nl_target = hmbd_pkg::NL_TARGET_LINE;
				end
			end
			hmbd_pkg::OP_START_PAY: begin
				if (st.input_ended) begin
					res.status = hmbd_pkg::ST_NEED_CLOSE;
				end else begin
					bytes_left_nxt = len;
					st_nxt.mode    = (len == '0) ? hmbd_pkg::MODE_IDLE : hmbd_pkg::MODE_PAYLOAD;
				end
			end
			hmbd_pkg::OP_START_CHNK: begin
				if (st.input_ended) begin
					res.status = hmbd_pkg::ST_NEED_CLOSE;
				end else begin
					st_nxt.mode       = hmbd_pkg::MODE_CSIZE;
					bytes_left_nxt    = '0;
					st_nxt.digit_seen = 1'b0;
					st_nxt.tail_space = 1'b0;
				end
			end
			hmbd_pkg::OP_END_INPUT: begin
				st_nxt.input_ended = 1'b1;
			end
			default: begin
				// unused codes leave everything as it is
			end
		endcase

		res.payload_consumed = (st_nxt.mode == hmbd_pkg::MODE_IDLE) && (bytes_left_nxt == '0);
	end

endmodule

>>> design/http_message_body_deframer.sv
// Top level of the HTTP message body deframer: state registers, result register.
// Depends on hmbd_pkg, hmbd_if (channels) and hmbd_core (per-request logic).

// Every request (a command or one received byte) yields exactly one result,
// registered and shown in the cycle after it is taken. A new request is taken in
// every cycle while the result channel drains; the rate is one request per clock.
// A stalled result holds the request channel off only while the result register is
// full and not being taken. Payload lengths are counted in LENGTH_BITS bits;
// chunk sizes that do not fit are reported as bad. After reset the block is ready
// at once.
module http_message_body_deframer #(
	parameter int LENGTH_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	hmbd_req_if.sink   req,
	hmbd_rsp_if.source rsp
);

	hmbd_pkg::ctl_state_t   st_q;
	hmbd_pkg::ctl_state_t   st_nxt;
	logic [LENGTH_BITS-1:0] bytes_left_q;
	logic [LENGTH_BITS-1:0] bytes_left_nxt;
	logic [LENGTH_BITS-1:0] len;
	logic [63:0]            len_ext;
	hmbd_pkg::rsp_t         res;
	hmbd_pkg::rsp_t         rsp_q;
	logic                   rsp_valid_q;
	logic                   take;

	// Length masked or widened to the counter width
	assign len_ext = {32'd0, req.payload_length};
	assign len     = len_ext[LENGTH_BITS-1:0];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign take      = req.valid && req.ready;

	hmbd_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.opcode        (req.opcode),
		.data_byte     (req.data_byte),
		.len           (len),
		.st            (st_q),
		.bytes_left    (bytes_left_q),
		.st_nxt        (st_nxt),
		.bytes_left_nxt(bytes_left_nxt),
		.res           (res)
	);

	// Framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode        <= hmbd_pkg::MODE_IDLE;
			st_q.nl_count    <= 2'd0;
			st_q.nl_target   <= 2'd0;
			st_q.input_ended <= 1'b0;
			st_q.digit_seen  <= 1'b0;
			st_q.tail_space  <= 1'b0;
			bytes_left_q     <= '0;
		end else if (take) begin
			st_q         <= st_nxt;
			bytes_left_q <= bytes_left_nxt;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.out_byte         = rsp_q.out_byte;
	assign rsp.byte_kind        = rsp_q.byte_kind;
	assign rsp.section_last     = rsp_q.section_last;
	assign rsp.payload_consumed = rsp_q.payload_consumed;
	assign rsp.status           = rsp_q.status;

endmodule

>>> design/hmbd_checker.sv
// Port-level checks for the message body deframer, bound to its top level.
// Depends on hmbd_pkg for the result codes.
module hmbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_out_byte,
	input logic [1:0] rsp_byte_kind,
	input logic       rsp_section_last,
	input logic       rsp_payload_consumed,
	input logic [1:0] rsp_status
);

	// Each taken request shows a result on the next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("request taken without a result next cycle");

	// A held result blocks new requests
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while result stalled");

	// A stalled result keeps its byte, kind and status
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
			$stable(rsp_byte_kind) && $stable(rsp_status))
		else $error("stalled result changed");

	// The end of a section always leaves nothing outstanding
	a_last_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_section_last |-> rsp_payload_consumed &&
			rsp_status == hmbd_pkg::ST_OK)
		else $error("section end with work outstanding");

	// A byte taken with no mode or after the end of input is never classified
	a_no_mode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == hmbd_pkg::ST_NO_MODE |->
			rsp_byte_kind == hmbd_pkg::KIND_NONE && !rsp_section_last)
		else $error("byte with no mode was classified");

endmodule

bind http_message_body_deframer hmbd_checker u_hmbd_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_out_byte        (rsp.out_byte),
	.rsp_byte_kind       (rsp.byte_kind),
	.rsp_section_last    (rsp.section_last),
	.rsp_payload_consumed(rsp.payload_consumed),
	.rsp_status          (rsp.status)
);
